FILE: rtl/segi_pkg.sv
package segi_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
endpackage

FILE: rtl/segi_if.sv
interface segi_req_if #(parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink   (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface segi_rsp_if #(parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
                        parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF);
   logic                                   valid;
   logic                                   ready;
   logic                                   hit;
   logic signed [COORD_BITS+FRAC_BITS-1:0] cross_x;
   logic signed [COORD_BITS+FRAC_BITS-1:0] cross_y;

   modport source (output valid, hit, cross_x, cross_y, input ready);
   modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

FILE: rtl/segi_div.sv
module segi_div #(
   parameter int DW = 34,
   parameter int NW = 60,
   parameter int QB = 24
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [NW-1:0]        num,
   input  logic                 neg,
   input  logic [DW-1:0]        den,
   output logic signed [QB-1:0] quot
);
   // one quotient bit per stage, restoring; quotient known to fit QB bits
   logic [DW-1:0] rem_ff  [QB];
   logic [QB-1:0] nlow_ff [QB];
   logic [QB-1:0] q_ff    [QB];
   logic [DW-1:0] den_ff  [QB];
   logic          neg_ff  [QB];

   genvar j;
   generate
      for (j = 0; j < QB; j++) begin : g_st
         logic [DW-1:0] rem_src;
         logic [QB-1:0] nlow_src;
         logic [QB-1:0] q_src;
         logic [DW-1:0] den_src;
         logic          neg_src;
         logic [DW:0]   trial;
         logic [DW:0]   diff;
         logic [DW-1:0] rem_in;
         logic [QB-1:0] q_in;

         if (j == 0) begin : g_first
            assign rem_src  = num[QB +: DW];
            assign nlow_src = num[QB-1:0];
            assign q_src    = '0;
            assign den_src  = den;
            assign neg_src  = neg;
         end else begin : g_next
            assign rem_src  = rem_ff[j-1];
            assign nlow_src = nlow_ff[j-1];
            assign q_src    = q_ff[j-1];
            assign den_src  = den_ff[j-1];
            assign neg_src  = neg_ff[j-1];
         end

         always_comb begin
            trial = {rem_src, nlow_src[QB-1]};
            diff  = trial - {1'b0, den_src};
            if (trial >= {1'b0, den_src}) begin
               rem_in = diff[DW-1:0];
               q_in   = {q_src[QB-2:0], 1'b1};
            end else begin
               rem_in = trial[DW-1:0];
               q_in   = {q_src[QB-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[j]  <= rem_in;
               nlow_ff[j] <= {nlow_src[QB-2:0], 1'b0};
               q_ff[j]    <= q_in;
               den_ff[j]  <= den_src;
               neg_ff[j]  <= neg_src;
            end
         end
      end
   endgenerate

   assign quot = neg_ff[QB-1] ? -$signed(q_ff[QB-1]) : $signed(q_ff[QB-1]);
endmodule

FILE: rtl/segment_intersection.sv
// channel | dir | handshake    | payload
// req_bus | in  | valid/ready  | a/b start/end x,y, COORD_BITS signed each
// rsp_bus | out | valid/ready  | hit, cross_x, cross_y (COORD_BITS+FRAC_BITS)
//
// One transaction per cycle sustained, but only while the output register is empty or taken.
// Depth is set by the restoring divider, one quotient bit per stage.
// All stages advance together whenever the output register is empty or taken.
// Synchronous active-high reset clears the valid bits only.
module segment_intersection #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
   input logic   clock,
   input logic   reset,
   segi_req_if.sink   req_bus,
   segi_rsp_if.source rsp_bus
);
   import segi_pkg::*;

   localparam int C    = COORD_BITS;
   localparam int SW   = C + 1;
   localparam int PW   = 2 * SW;
   localparam int DENW = PW + 1;
   localparam int DW   = DENW - 1;
   localparam int MW   = DENW + SW;
   localparam int SUMW = MW + 1;
   localparam int NW   = SUMW + FRAC_BITS;
   localparam int QB   = C + FRAC_BITS;
   localparam int LAT  = 6 + QB;

   logic adv;
   logic vld_ff [LAT];
   logic hit_ff [LAT-3];

   // stage 1: differences
   logic signed [SW-1:0] s1x_ff, s1y_ff, s2x_ff, s2y_ff, dx_ff, dy_ff;
   logic signed [C-1:0]  p0x1_ff, p0y1_ff;
   // stage 2: products
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [SW-1:0] s1x2_ff, s1y2_ff;
   logic signed [C-1:0]  p0x2_ff, p0y2_ff;
   // stage 3: den and numerators
   logic signed [DENW-1:0] den_ff, snum_ff, tnum_ff;
   logic signed [SW-1:0]   s1x3_ff, s1y3_ff;
   logic signed [C-1:0]    p0x3_ff, p0y3_ff;
   // stage 4: sign normalised
   logic [DW-1:0]          dena_ff;
   logic signed [DENW-1:0] tnf_ff;
   logic signed [SW-1:0]   s1x4_ff, s1y4_ff;
   logic signed [C-1:0]    p0x4_ff, p0y4_ff;
   // stage 5: point numerator products
   logic signed [MW-1:0] px_ff, py_ff, tx_ff, ty_ff;
   logic [DW-1:0]        den5_ff;
   // stage 6: magnitudes for the divider
   logic [NW-1:0] numx_ff, numy_ff;
   logic          negx_ff, negy_ff;
   logic [DW-1:0] den6_ff;

   logic signed [DENW-1:0] den_in, snf_in, tnf_in;
   logic [DW-1:0]          dena_in;
   logic                   hit_in;
   logic signed [SUMW-1:0] sumx, sumy;
   logic [SUMW-1:0]        magx, magy;
   logic signed [QB-1:0]   qx, qy;

   logic                 rsp_valid_ff, rsp_hit_ff;
   logic signed [QB-1:0] rsp_x_ff, rsp_y_ff;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_comb begin
      den_in = den_ff;
      snf_in = snum_ff;
      tnf_in = tnum_ff;
      if (den_ff[DENW-1]) begin
         den_in = -den_ff;
         snf_in = -snum_ff;
         tnf_in = -tnum_ff;
      end
      dena_in = den_in[DW-1:0];
      hit_in  = (dena_in != '0) && !snf_in[DENW-1] && (snf_in <= den_in)
                && !tnf_in[DENW-1] && (tnf_in <= den_in);
   end

   assign sumx = SUMW'(px_ff) + SUMW'(tx_ff);
   assign sumy = SUMW'(py_ff) + SUMW'(ty_ff);
   assign magx = sumx[SUMW-1] ? -sumx : sumx;
   assign magy = sumy[SUMW-1] ? -sumy : sumy;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1x_ff  <= SW'(req_bus.a_end_x)   - SW'(req_bus.a_start_x);
         s1y_ff  <= SW'(req_bus.a_end_y)   - SW'(req_bus.a_start_y);
         s2x_ff  <= SW'(req_bus.b_end_x)   - SW'(req_bus.b_start_x);
         s2y_ff  <= SW'(req_bus.b_end_y)   - SW'(req_bus.b_start_y);
         dx_ff   <= SW'(req_bus.a_start_x) - SW'(req_bus.b_start_x);
         dy_ff   <= SW'(req_bus.a_start_y) - SW'(req_bus.b_start_y);
         p0x1_ff <= req_bus.a_start_x;
         p0y1_ff <= req_bus.a_start_y;

         m0_ff   <= PW'(s1x_ff) * PW'(s2y_ff);
         m1_ff   <= PW'(s2x_ff) * PW'(s1y_ff);
         m2_ff   <= PW'(s1x_ff) * PW'(dy_ff);
         m3_ff   <= PW'(s1y_ff) * PW'(dx_ff);
         m4_ff   <= PW'(s2x_ff) * PW'(dy_ff);
         m5_ff   <= PW'(s2y_ff) * PW'(dx_ff);
         s1x2_ff <= s1x_ff;
         s1y2_ff <= s1y_ff;
         p0x2_ff <= p0x1_ff;
         p0y2_ff <= p0y1_ff;

         den_ff  <= DENW'(m0_ff) - DENW'(m1_ff);
         snum_ff <= DENW'(m2_ff) - DENW'(m3_ff);
         tnum_ff <= DENW'(m4_ff) - DENW'(m5_ff);
         s1x3_ff <= s1x2_ff;
         s1y3_ff <= s1y2_ff;
         p0x3_ff <= p0x2_ff;
         p0y3_ff <= p0y2_ff;

         dena_ff <= dena_in;
         tnf_ff  <= tnf_in;
         s1x4_ff <= s1x3_ff;
         s1y4_ff <= s1y3_ff;
         p0x4_ff <= p0x3_ff;
         p0y4_ff <= p0y3_ff;

         px_ff   <= MW'(p0x4_ff) * $signed(MW'({1'b0, dena_ff}));
         py_ff   <= MW'(p0y4_ff) * $signed(MW'({1'b0, dena_ff}));
         tx_ff   <= MW'(tnf_ff) * MW'(s1x4_ff);
         ty_ff   <= MW'(tnf_ff) * MW'(s1y4_ff);
         den5_ff <= dena_ff;

         numx_ff <= NW'(magx) << FRAC_BITS;
         numy_ff <= NW'(magy) << FRAC_BITS;
         negx_ff <= sumx[SUMW-1];
         negy_ff <= sumy[SUMW-1];
         den6_ff <= den5_ff;
      end
   end

   segi_div #(.DW(DW), .NW(NW), .QB(QB)) u_div_x (
      .clock (clock), .adv (adv), .num (numx_ff), .neg (negx_ff),
      .den (den6_ff), .quot (qx)
   );

   segi_div #(.DW(DW), .NW(NW), .QB(QB)) u_div_y (
      .clock (clock), .adv (adv), .num (numy_ff), .neg (negy_ff),
      .den (den6_ff), .quot (qy)
   );

   // valid and hit travel alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) vld_ff[k] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_bus.valid;
         for (int k = 1; k < LAT; k++) vld_ff[k] <= vld_ff[k-1];
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff[0] <= hit_in;
         for (int k = 1; k < LAT-3; k++) hit_ff[k] <= hit_ff[k-1];
         rsp_hit_ff <= hit_ff[LAT-4];
         rsp_x_ff   <= hit_ff[LAT-4] ? qx : '0;
         rsp_y_ff   <= hit_ff[LAT-4] ? qy : '0;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.hit     = rsp_hit_ff;
   assign rsp_bus.cross_x = rsp_x_ff;
   assign rsp_bus.cross_y = rsp_y_ff;

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_hit_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0)
      else $error("miss with nonzero point");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> rsp_valid_ff && $stable(rsp_x_ff))
      else $error("stalled result lost");
   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("input taken during stall");
endmodule
